// ----- rtl/ast_pkg.sv -----
// ============================================================================
// ast_pkg
// Shared types, codes and sizes for the alarm schedule table.
// ============================================================================
package ast_pkg;

  // Table size and the widths that follow from it.
  localparam int ENTRIES = 8;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  // Selector constants.
  localparam logic [7:0] SEL_ANY = 8'hFF;
  localparam logic [7:0] DAY_ANY = 8'h80;

  // Operation codes.
  localparam logic [2:0] OP_TICK   = 3'd0;
  localparam logic [2:0] OP_ADD    = 3'd1;
  localparam logic [2:0] OP_REMOVE = 3'd2;
  localparam logic [2:0] OP_UPDATE = 3'd3;
  localparam logic [2:0] OP_STATS  = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_FIRED  = 3'd0;
  localparam logic [2:0] KIND_ADD    = 3'd1;
  localparam logic [2:0] KIND_REMOVE = 3'd2;
  localparam logic [2:0] KIND_UPDATE = 3'd3;
  localparam logic [2:0] KIND_STATS  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // One input item.
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] slot_index;
    logic [7:0] minute_sel;
    logic [7:0] hour_sel;
    logic [7:0] weekday_mask;
    logic [7:0] action_code;
    logic       enable_bit;
    logic [5:0] now_minute;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  status;
    logic [2:0]  slot;
    logic [7:0]  fired_action;
    logic [3:0]  enabled_count;
    logic [31:0] fire_total;
    logic        last;
  } out_item_t;

  // One stored alarm entry.
  typedef struct packed {
    logic [7:0] minute;
    logic [7:0] hour;
    logic [7:0] mask;
    logic [7:0] action;
    logic       enabled;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_end;
  } dp_status_t;

endpackage

// ----- rtl/ast_ctrl.sv -----
// ============================================================================
// ast_ctrl
// Sequencer for the alarm schedule table: accept, table scan and finish.
// ============================================================================
module ast_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [2:0]          op,
  input  ast_pkg::dp_status_t sts,
  output logic                busy,
  output ast_pkg::ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (op == ast_pkg::OP_TICK || op == ast_pkg::OP_ADD ||
              op == ast_pkg::OP_STATS) begin
            state_nxt = S_SCAN;
          end else if (op == ast_pkg::OP_REMOVE || op == ast_pkg::OP_UPDATE) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        cmd.step = 1'b1;
        if (sts.scan_end) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/ast_dp.sv -----
// ============================================================================
// ast_dp
// Datapath: entry table, rearm flags, fire counter, scan pointer and the
// result register.
// ============================================================================
module ast_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  ast_pkg::in_item_t   in_data,
  input  ast_pkg::ctrl_cmd_t  cmd,
  output ast_pkg::dp_status_t sts,
  output logic                out_valid,
  output ast_pkg::out_item_t  out_data
);

  ast_pkg::entry_t               table_r   [ast_pkg::ENTRIES];
  ast_pkg::entry_t               table_nxt [ast_pkg::ENTRIES];
  logic [ast_pkg::ENTRIES-1:0]   armed_r, armed_nxt;
  logic [31:0]                   fire_cnt_r, fire_cnt_nxt;
  ast_pkg::in_item_t             item_r, item_nxt;
  logic [ast_pkg::IDX_W-1:0]     idx_r, idx_nxt;
  logic [ast_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                          found_r, found_nxt;
  logic [ast_pkg::IDX_W-1:0]     found_slot_r, found_slot_nxt;
  logic                          pend_v_r, pend_v_nxt;
  logic [ast_pkg::IDX_W-1:0]     pend_slot_r, pend_slot_nxt;
  logic [7:0]                    pend_act_r, pend_act_nxt;
  logic [31:0]                   pend_total_r, pend_total_nxt;
  logic                          out_valid_r, out_valid_nxt;
  ast_pkg::out_item_t            out_data_r, out_data_nxt;

  ast_pkg::entry_t               cur;
  logic                          hit;
  logic [31:0]                   fire_inc;
  logic                          slot_ok;
  logic [ast_pkg::IDX_W-1:0]     slot_addr;

  // Schedule match of one entry against the tick time.
  function automatic logic entry_matches(ast_pkg::entry_t e, logic [5:0] mi,
                                         logic [4:0] hr, logic [2:0] wd);
    logic [2:0] dow;
    logic       ok;
    ok = 1'b1;
    if (e.minute != ast_pkg::SEL_ANY && e.minute != {2'b00, mi}) ok = 1'b0;
    if (e.hour != ast_pkg::SEL_ANY && e.hour != {3'b000, hr}) ok = 1'b0;
    if ((e.mask & ast_pkg::DAY_ANY) == 8'h00) begin
      // Sunday and the out-of-range code seven share mask bit six.
      dow = (wd == 3'd0 || wd == 3'd7) ? 3'd6 : wd - 3'd1;
      if (!e.mask[dow]) ok = 1'b0;
    end
    return ok;
  endfunction

  // Entry built from the fields of an item.
  function automatic ast_pkg::entry_t load_entry(ast_pkg::in_item_t it);
    ast_pkg::entry_t e;
    e.minute  = it.minute_sel;
    e.hour    = it.hour_sel;
    e.mask    = it.weekday_mask;
    e.action  = it.action_code;
    e.enabled = it.enable_bit;
    return e;
  endfunction

  assign cur       = table_r[idx_r];
  assign hit       = entry_matches(cur, item_r.now_minute, item_r.now_hour,
                                   item_r.now_weekday);
  assign fire_inc  = fire_cnt_r + 32'd1;
  assign slot_ok   = ({1'b0, item_r.slot_index} < 9'(ast_pkg::ENTRIES));
  assign slot_addr = item_r.slot_index[ast_pkg::IDX_W-1:0];
  assign sts.scan_end = (idx_r == ast_pkg::IDX_W'(ast_pkg::ENTRIES - 1));

  // Next-state logic for the whole datapath.
  always_comb begin
    table_nxt      = table_r;
    armed_nxt      = armed_r;
    fire_cnt_nxt   = fire_cnt_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    pend_v_nxt     = pend_v_r;
    pend_slot_nxt  = pend_slot_r;
    pend_act_nxt   = pend_act_r;
    pend_total_nxt = pend_total_r;
    out_valid_nxt  = 1'b0;
    out_data_nxt   = out_data_r;

    // Capture the accepted item and clear the scan state.
    if (cmd.load) begin
      item_nxt       = in_data;
      idx_nxt        = '0;
      cnt_nxt        = '0;
      found_nxt      = 1'b0;
      found_slot_nxt = '0;
      pend_v_nxt     = 1'b0;
    end

    // One table entry per cycle.
    if (cmd.step) begin
      idx_nxt = idx_r + ast_pkg::IDX_W'(1);
      case (item_r.op)
        ast_pkg::OP_TICK: begin
          if (cur.enabled) begin
            if (!hit) begin
              armed_nxt[idx_r] = 1'b0;
            end else if (!armed_r[idx_r]) begin
              fire_cnt_nxt     = fire_inc;
              armed_nxt[idx_r] = 1'b1;
              // A held firing is now known not to be the final one.
              if (pend_v_r) begin
                out_valid_nxt             = 1'b1;
                out_data_nxt              = '0;
                out_data_nxt.kind         = ast_pkg::KIND_FIRED;
                out_data_nxt.slot         = 3'(pend_slot_r);
                out_data_nxt.fired_action = pend_act_r;
                out_data_nxt.fire_total   = pend_total_r;
              end
              pend_v_nxt     = 1'b1;
              pend_slot_nxt  = idx_r;
              pend_act_nxt   = cur.action;
              pend_total_nxt = fire_inc;
            end
          end
        end
        ast_pkg::OP_ADD: begin
          if (!cur.enabled && !found_r) begin
            table_nxt[idx_r] = load_entry(item_r);
            found_nxt        = 1'b1;
            found_slot_nxt   = idx_r;
          end
        end
        ast_pkg::OP_STATS: begin
          if (cur.enabled) begin
            cnt_nxt = cnt_r + ast_pkg::CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end

    // Final result of the item.
    if (cmd.finish) begin
      out_data_nxt      = '0;
      out_data_nxt.last = 1'b1;
      case (item_r.op)
        ast_pkg::OP_TICK: begin
          out_valid_nxt             = pend_v_r;
          out_data_nxt.kind         = ast_pkg::KIND_FIRED;
          out_data_nxt.slot         = 3'(pend_slot_r);
          out_data_nxt.fired_action = pend_act_r;
          out_data_nxt.fire_total   = pend_total_r;
          pend_v_nxt                = 1'b0;
        end
        ast_pkg::OP_ADD: begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = ast_pkg::KIND_ADD;
          out_data_nxt.status = found_r ? ast_pkg::ST_OK : ast_pkg::ST_FULL;
          out_data_nxt.slot   = found_r ? 3'(found_slot_r) : 3'd0;
        end
        ast_pkg::OP_REMOVE: begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = ast_pkg::KIND_REMOVE;
          out_data_nxt.status = slot_ok ? ast_pkg::ST_OK : ast_pkg::ST_BAD_SLOT;
          if (slot_ok) begin
            table_nxt[slot_addr] = '0;
          end
        end
        ast_pkg::OP_UPDATE: begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.kind   = ast_pkg::KIND_UPDATE;
          out_data_nxt.status = slot_ok ? ast_pkg::ST_OK : ast_pkg::ST_BAD_SLOT;
          if (slot_ok) begin
            table_nxt[slot_addr] = load_entry(item_r);
          end
        end
        ast_pkg::OP_STATS: begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.kind          = ast_pkg::KIND_STATS;
          out_data_nxt.enabled_count = 4'(cnt_r);
          out_data_nxt.fire_total    = fire_cnt_r;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and architectural state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ast_pkg::ENTRIES; i++) begin
        table_r[i] <= '0;
      end
      armed_r     <= '0;
      fire_cnt_r  <= '0;
      idx_r       <= '0;
      cnt_r       <= '0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      table_r     <= table_nxt;
      armed_r     <= armed_nxt;
      fire_cnt_r  <= fire_cnt_nxt;
      idx_r       <= idx_nxt;
      cnt_r       <= cnt_nxt;
      found_r     <= found_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    found_slot_r <= found_slot_nxt;
    pend_slot_r  <= pend_slot_nxt;
    pend_act_r   <= pend_act_nxt;
    pend_total_r <= pend_total_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/alarm_schedule_table_top.sv -----
// ============================================================================
// alarm_schedule_table_top
// Alarm schedule table: cron-like matching of eight alarm entries.
// ============================================================================
// Usage:
//   A command is transferred on a rising edge with start high and busy low;
//   in_data carries the operation and its fields. Results appear on out_data
//   for exactly one cycle, marked by out_valid; the receiver cannot stall,
//   so each result is transferred in the cycle it is shown.
//   Tick, add and stats walk the entry table one slot per cycle, then take a
//   finish step; busy stays high through the scan and the finish step, so no
//   new command is taken until both are done. Remove and update skip the
//   scan and hold busy for the finish step only. Unused op codes are
//   taken and dropped without a result.
//   A tick gives one result per firing entry, in slot order, the last one
//   marked by last; each firing is held until the next one is found in the
//   scan, and the final one is shown after the finish step. Other commands
//   give one result, also after the finish step.
//   Synchronous reset (rst_n low) disables every entry, clears the rearm
//   flags and the fire counter, and returns the sequencer to idle.
// ============================================================================
module alarm_schedule_table_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ast_pkg::in_item_t  in_data,
  output logic               out_valid,
  output ast_pkg::out_item_t out_data
);

  ast_pkg::ctrl_cmd_t  cmd;
  ast_pkg::dp_status_t sts;

  // Sequencer.
  ast_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_data.op),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Table and result datapath.
  ast_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the alarm schedule table.
// A queue of commands, built at time zero, feeds a falling-edge driver; a
// rising-edge monitor predicts the results of every transferred command and
// compares each strobed result, field by field, with the oldest prediction.
// ============================================================================
module tb_top;

  // Bench sizes.
  localparam int RAND_ITEMS   = 96;
  localparam int PHASE_LEN    = 24;
  localparam int DRAIN_CYCLES = ast_pkg::ENTRIES + 6;
  localparam int CYCLE_LIMIT  = 200000;

  // A command waiting in the driver queue, with its idling behaviour.
  typedef struct {
    ast_pkg::in_item_t cmd;
    int unsigned       gap_pct;
    bit                drain_first;
  } pending_t;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               start   = 1'b0;
  ast_pkg::in_item_t  in_data = '0;
  logic               busy;
  logic               out_valid;
  ast_pkg::out_item_t out_data;

  pending_t           cmd_q [$];
  ast_pkg::out_item_t alarm_results_due [$];
  int unsigned        phase_gap  = 0;
  bit                 drain_next = 1'b0;

  // Predicted block state.
  ast_pkg::entry_t    sched_entries [ast_pkg::ENTRIES];
  logic               fire_held [ast_pkg::ENTRIES];
  logic [31:0]        fire_total_model;

  // Handshake tracking and counters.
  logic        xfer_done = 1'b0;
  int          quiet_cycles = 0;
  int          items_taken = 0;
  int          results_seen = 0;
  int          firings_seen = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          n_items;

  alarm_schedule_table_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // Free-running clock.
  always #2 clk = ~clk;

  // True when an entry's selectors accept the given time.
  function automatic logic alarm_matches(input ast_pkg::entry_t e, input logic [5:0] mi,
                                         input logic [4:0] hr, input logic [2:0] wd);
    logic [2:0] dow;
    // Weekday 0 and the out-of-range 7 both mean Sunday, mask bit 6.
    dow = (wd == 3'd0 || wd == 3'd7) ? 3'd6 : wd - 3'd1;
    if (e.minute != ast_pkg::SEL_ANY && e.minute != {2'b00, mi}) return 1'b0;
    if (e.hour != ast_pkg::SEL_ANY && e.hour != {3'b000, hr}) return 1'b0;
    if ((e.mask & ast_pkg::DAY_ANY) == 8'h00 && !e.mask[dow]) return 1'b0;
    return 1'b1;
  endfunction

  // Applies one transferred command to the predicted state and queues its results.
  task automatic predict_alarm_results(input ast_pkg::in_item_t cmd);
    ast_pkg::out_item_t res [ast_pkg::ENTRIES];
    ast_pkg::out_item_t r;
    int                 n;
    int                 i;
    bit                 placed;
    logic [3:0]         cnt;
    n = 0;
    r = '0;
    placed = 1'b0;
    cnt = '0;
    case (cmd.op)
      ast_pkg::OP_TICK: begin
        for (i = 0; i < ast_pkg::ENTRIES; i++) begin
          if (sched_entries[i].enabled) begin
            if (!alarm_matches(sched_entries[i], cmd.now_minute, cmd.now_hour,
                               cmd.now_weekday)) begin
              fire_held[i] = 1'b0;
            end else if (!fire_held[i]) begin
              fire_total_model = fire_total_model + 32'd1;
              fire_held[i] = 1'b1;
              r = '0;
              r.kind = ast_pkg::KIND_FIRED;
              r.slot = 3'(i);
              r.fired_action = sched_entries[i].action;
              r.fire_total = fire_total_model;
              res[n] = r;
              n++;
            end
          end
        end
      end
      ast_pkg::OP_ADD: begin
        r.kind = ast_pkg::KIND_ADD;
        for (i = 0; i < ast_pkg::ENTRIES; i++) begin
          if (!placed && !sched_entries[i].enabled) begin
            sched_entries[i] = '{cmd.minute_sel, cmd.hour_sel, cmd.weekday_mask,
                                 cmd.action_code, cmd.enable_bit};
            r.slot = 3'(i);
            placed = 1'b1;
          end
        end
        if (!placed) r.status = ast_pkg::ST_FULL;
        res[0] = r;
        n = 1;
      end
      ast_pkg::OP_REMOVE, ast_pkg::OP_UPDATE: begin
        r.kind = (cmd.op == ast_pkg::OP_REMOVE) ? ast_pkg::KIND_REMOVE
                                                : ast_pkg::KIND_UPDATE;
        if (cmd.slot_index < ast_pkg::ENTRIES) begin
          // Removal leaves the fired flag as it was.
          if (cmd.op == ast_pkg::OP_REMOVE) sched_entries[cmd.slot_index] = '0;
          else sched_entries[cmd.slot_index] = '{cmd.minute_sel, cmd.hour_sel,
                                                 cmd.weekday_mask, cmd.action_code,
                                                 cmd.enable_bit};
        end else begin
          r.status = ast_pkg::ST_BAD_SLOT;
        end
        res[0] = r;
        n = 1;
      end
      ast_pkg::OP_STATS: begin
        for (i = 0; i < ast_pkg::ENTRIES; i++)
          if (sched_entries[i].enabled) cnt = cnt + 4'd1;
        r.kind = ast_pkg::KIND_STATS;
        r.enabled_count = cnt;
        r.fire_total = fire_total_model;
        res[0] = r;
        n = 1;
      end
      default: begin
        // Unused codes are dropped without a result.
      end
    endcase
    if (n > 0) res[n - 1].last = 1'b1;
    for (i = 0; i < n; i++) alarm_results_due.push_back(res[i]);
  endtask

  // Reports one field that differs from its prediction.
  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      err_cnt++;
    end
  endtask

  // Monitor: checks strobed results and predicts every transfer.
  always @(posedge clk) begin : monitor
    ast_pkg::out_item_t exp_r;
    int                 i;
    if (!rst_n) begin
      for (i = 0; i < ast_pkg::ENTRIES; i++) begin
        sched_entries[i] = '0;
        fire_held[i] = 1'b0;
      end
      fire_total_model = '0;
      xfer_done <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_valid) begin
        results_seen++;
        if (alarm_results_due.size() == 0) begin
          $error("result with nothing predicted: kind %0d slot %0d",
                 out_data.kind, out_data.slot);
          err_cnt++;
        end else begin
          exp_r = alarm_results_due.pop_front();
          if (exp_r.kind == ast_pkg::KIND_FIRED) firings_seen++;
          check_field("kind", 32'(exp_r.kind), 32'(out_data.kind));
          check_field("status", 32'(exp_r.status), 32'(out_data.status));
          check_field("slot", 32'(exp_r.slot), 32'(out_data.slot));
          check_field("fired_action", 32'(exp_r.fired_action), 32'(out_data.fired_action));
          check_field("enabled_count", 32'(exp_r.enabled_count),
                      32'(out_data.enabled_count));
          check_field("fire_total", exp_r.fire_total, out_data.fire_total);
          check_field("last", 32'(exp_r.last), 32'(out_data.last));
        end
      end
      if (start && !busy) begin
        predict_alarm_results(in_data);
        items_taken++;
      end
      xfer_done <= start && !busy;
      quiet_cycles <= (out_valid || (start && !busy)) ? 0 : quiet_cycles + 1;
    end
  end

  // Driver: offers the next queued command once the previous one is transferred.
  always @(negedge clk) begin : driver
    pending_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || xfer_done) begin
      if (cmd_q.size() == 0) begin
        start <= 1'b0;
      end else if (cmd_q[0].drain_first &&
                   !(alarm_results_due.size() == 0 && quiet_cycles >= DRAIN_CYCLES
                     && !busy)) begin
        // Hold off until the block has gone quiet.
        start <= 1'b0;
      end else if ($urandom_range(99) < cmd_q[0].gap_pct) begin
        start <= 1'b0;
      end else begin
        nxt = cmd_q.pop_front();
        in_data <= nxt.cmd;
        start <= 1'b1;
      end
    end
  end

  // Stimulus helpers.
  task automatic queue_cmd(input ast_pkg::in_item_t c);
    pending_t p;
    p.cmd = c;
    p.gap_pct = phase_gap;
    p.drain_first = drain_next;
    drain_next = 1'b0;
    cmd_q.push_back(p);
  endtask

  // Every field random, so that fields an operation ignores still toggle.
  function automatic ast_pkg::in_item_t noise_cmd();
    ast_pkg::in_item_t c;
    c.op           = 3'($urandom_range(7));
    c.slot_index   = 8'($urandom_range(255));
    c.minute_sel   = 8'($urandom_range(255));
    c.hour_sel     = 8'($urandom_range(255));
    c.weekday_mask = 8'($urandom_range(255));
    c.action_code  = 8'($urandom_range(255));
    c.enable_bit   = 1'($urandom_range(1));
    c.now_minute   = 6'($urandom_range(63));
    c.now_hour     = 5'($urandom_range(31));
    c.now_weekday  = 3'($urandom_range(7));
    return c;
  endfunction

  function automatic ast_pkg::in_item_t op_cmd(input logic [2:0] op, input logic [7:0] slot);
    ast_pkg::in_item_t c;
    c = noise_cmd();
    c.op = op;
    c.slot_index = slot;
    return c;
  endfunction

  function automatic ast_pkg::in_item_t entry_cmd(input logic [2:0] op,
                                                  input logic [7:0] slot,
                                                  input logic [7:0] mi,
                                                  input logic [7:0] hr,
                                                  input logic [7:0] mask,
                                                  input logic [7:0] act,
                                                  input logic en);
    ast_pkg::in_item_t c;
    c = op_cmd(op, slot);
    c.minute_sel = mi;
    c.hour_sel = hr;
    c.weekday_mask = mask;
    c.action_code = act;
    c.enable_bit = en;
    return c;
  endfunction

  function automatic ast_pkg::in_item_t tick_cmd(input logic [5:0] mi, input logic [4:0] hr,
                                                 input logic [2:0] wd);
    ast_pkg::in_item_t c;
    c = op_cmd(ast_pkg::OP_TICK, 8'($urandom_range(255)));
    c.now_minute = mi;
    c.now_hour = hr;
    c.now_weekday = wd;
    return c;
  endfunction

  // A small pool of times keeps ticks and entries meeting often.
  function automatic logic [5:0] pool_minute();
    case ($urandom_range(3))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd30;
      default: return 6'd59;
    endcase
  endfunction

  function automatic logic [4:0] pool_hour();
    case ($urandom_range(2))
      0: return 5'd0;
      1: return 5'd7;
      default: return 5'd23;
    endcase
  endfunction

  function automatic logic [7:0] pick_slot();
    if ($urandom_range(9) < 8) return 8'($urandom_range(ast_pkg::ENTRIES - 1));
    return 8'($urandom_range(255));
  endfunction

  function automatic ast_pkg::in_item_t random_entry_cmd(input logic [2:0] op);
    logic [7:0] mi;
    logic [7:0] hr;
    logic [7:0] mask;
    int         r;
    r = $urandom_range(9);
    mi = (r < 3) ? ast_pkg::SEL_ANY : (r == 3) ? 8'($urandom_range(255))
                                               : {2'b00, pool_minute()};
    r = $urandom_range(9);
    hr = (r < 3) ? ast_pkg::SEL_ANY : (r == 3) ? 8'($urandom_range(255))
                                               : {3'b000, pool_hour()};
    case ($urandom_range(3))
      0: mask = ast_pkg::DAY_ANY | 8'($urandom_range(127));
      1: mask = 8'h7F;
      default: mask = 8'($urandom_range(255));
    endcase
    return entry_cmd(op, pick_slot(), mi, hr, mask, 8'($urandom_range(255)),
                     1'($urandom_range(99) < 85));
  endfunction

  // Build the command list, run it and report.
  initial begin : stimulus
    int n;
    int roll;
    logic [5:0] tmi;
    logic [4:0] thr;

    // Directed part: empty table, filling, full table, firing and re-arming.
    queue_cmd(op_cmd(ast_pkg::OP_STATS, 8'd0));
    queue_cmd(tick_cmd(6'd0, 5'd0, 3'd1));
    queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, 8'd0, 8'd0, 8'h01, 8'h00, 1'b1));
    queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, ast_pkg::SEL_ANY, ast_pkg::SEL_ANY,
                        ast_pkg::DAY_ANY, 8'hFF, 1'b1));
    // A disabled entry still takes a slot, and the next add reuses it.
    queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, 8'd59, 8'd23, 8'h40, 8'hAA, 1'b0));
    queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, ast_pkg::SEL_ANY, 8'd0, 8'h7F, 8'h5A, 1'b1));
    for (n = 3; n < ast_pkg::ENTRIES; n++)
      queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, ast_pkg::SEL_ANY, ast_pkg::SEL_ANY,
                          ast_pkg::DAY_ANY, 8'(n), 1'b1));
    // Table full.
    queue_cmd(entry_cmd(ast_pkg::OP_ADD, 8'd0, 8'd1, 8'd1, 8'h01, 8'h01, 1'b1));
    queue_cmd(op_cmd(ast_pkg::OP_STATS, 8'd0));
    // Every entry fires once, then holds while it keeps matching.
    queue_cmd(tick_cmd(6'd0, 5'd0, 3'd1));
    queue_cmd(tick_cmd(6'd0, 5'd0, 3'd1));
    queue_cmd(tick_cmd(6'd59, 5'd23, 3'd0));
    // Removal keeps the fired flag, so the rewritten entry stays quiet.
    queue_cmd(op_cmd(ast_pkg::OP_REMOVE, 8'd1));
    queue_cmd(entry_cmd(ast_pkg::OP_UPDATE, 8'd1, 8'd59, 8'd23, 8'h40, 8'h11, 1'b1));
    queue_cmd(tick_cmd(6'd59, 5'd23, 3'd7));
    // Out-of-range time re-arms it; the next match fires.
    queue_cmd(tick_cmd(6'd63, 5'd31, 3'd7));
    queue_cmd(tick_cmd(6'd59, 5'd23, 3'd0));
    queue_cmd(op_cmd(ast_pkg::OP_REMOVE, 8'hFF));
    queue_cmd(entry_cmd(ast_pkg::OP_UPDATE, 8'(ast_pkg::ENTRIES), 8'd0, 8'd0, 8'h00,
                        8'h00, 1'b1));
    queue_cmd(op_cmd(3'd5, 8'd0));
    queue_cmd(op_cmd(3'd6, 8'd0));
    queue_cmd(op_cmd(3'd7, 8'd0));
    queue_cmd(op_cmd(ast_pkg::OP_STATS, 8'd0));

    // Random part in four idling phases, each opened after the block drains.
    for (n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        drain_next = 1'b1;
        case (n / PHASE_LEN)
          1: phase_gap = 86;
          3: phase_gap = 33;
          default: phase_gap = 0;
        endcase
      end else if ($urandom_range(99) < 3) begin
        drain_next = 1'b1;
      end
      roll = $urandom_range(99);
      if (roll < 48) begin
        tmi = ($urandom_range(9) < 8) ? pool_minute() : 6'($urandom_range(63));
        thr = ($urandom_range(9) < 8) ? pool_hour() : 5'($urandom_range(31));
        queue_cmd(tick_cmd(tmi, thr, 3'($urandom_range(7))));
      end else if (roll < 63) begin
        queue_cmd(random_entry_cmd(ast_pkg::OP_ADD));
      end else if (roll < 73) begin
        queue_cmd(op_cmd(ast_pkg::OP_REMOVE, pick_slot()));
      end else if (roll < 88) begin
        queue_cmd(random_entry_cmd(ast_pkg::OP_UPDATE));
      end else if (roll < 96) begin
        queue_cmd(op_cmd(ast_pkg::OP_STATS, pick_slot()));
      end else begin
        queue_cmd(op_cmd(3'($urandom_range(7, 5)), pick_slot()));
      end
    end
    n_items = cmd_q.size();

    // Reset, released on a falling edge.
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every transfer, every result and a quiet tail.
    while (items_taken != n_items) @(negedge clk);
    while (alarm_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("tb_top: %0d commands transferred, %0d results checked, %0d firings",
             items_taken, results_seen, firings_seen);
    $display("tb_top: %0d mismatches or stray results", err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_top: timeout after %0d cycles", cycle_cnt);
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
